// ===== hw/rtl/teq_pkg.sv =====
// types and codes shared by the timed event queue modules
// no dependencies
package teq_pkg;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DEL_PARAM = 3'd1;
  localparam logic [2:0] OP_DEL_KIND  = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_ADVANCE   = 3'd4;

  localparam logic [2:0] CLS_ONCE     = 3'd0;
  localparam logic [2:0] CLS_RANGED   = 3'd1;
  localparam logic [2:0] CLS_END      = 3'd2;
  localparam logic [2:0] CLS_PERIODIC = 3'd3;
  localparam logic [2:0] CLS_DAILY    = 3'd4;

  localparam logic [1:0] RK_DISPATCH = 2'd0;
  localparam logic [1:0] RK_DONE     = 2'd1;
  localparam logic [1:0] RK_FULL     = 2'd2;
  localparam logic [1:0] RK_NOTFOUND = 2'd3;

  localparam int unsigned MaxDispatch = 63;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  event_kind;
    logic [2:0]  event_class;
    logic [31:0] due_stamp;
    logic [31:0] time_offset;
    logic [31:0] event_param;
    logic [31:0] adjustment;
    logic        warp_target_first;
  } teq_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_kind;
    logic [2:0]  out_class;
    logic [31:0] out_param;
    logic [31:0] out_stamp;
    logic [31:0] clock_now;
    logic        last;
  } teq_out_t;

  // one stored entry
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] param;
    logic [31:0] offset;
    logic [7:0]  kind;
    logic [2:0]  cls;
  } teq_entry_t;

endpackage

// ===== hw/rtl/timed_event_queue.sv =====
// Timed event queue: a sorted store of up to QUEUE_DEPTH events in one
// single-port-write memory, walked by a sequencer that reads one entry at a
// time (registered read plus a wait state, S_WAIT, on scans) and moves one
// entry at a time on shifts, a read and then a write. An insert or a single
// delete scans for its position and shifts the entries behind it; delete-by-kind
// repeats the shift for every match, and an advance that reposts a dispatched
// event runs a removal shift, then a sorted insert, for that event.
// Results leave through an output register; in_stall_o is high while busy or while a held output word is stalled.
// depends on teq_pkg and teq_store
module timed_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned DAY_SECONDS = 86400
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  teq_pkg::teq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output teq_pkg::teq_out_t out_data_o
);
  import teq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIND   = 4'd1;  // scan for insert position
  localparam logic [3:0] S_SHUP   = 4'd2;  // shift towards tail
  localparam logic [3:0] S_PUT    = 4'd3;  // write new entry
  localparam logic [3:0] S_SRCH   = 4'd4;  // scan for deletion match
  localparam logic [3:0] S_SHDN   = 4'd5;  // shift towards head
  localparam logic [3:0] S_ADV    = 4'd6;  // examine entry for advance
  localparam logic [3:0] S_EMIT   = 4'd7;  // wait for output register
  localparam logic [3:0] S_FIN    = 4'd8;  // final result
  localparam logic [3:0] S_WAIT   = 4'd9;  // read latency
  localparam logic [3:0] S_AFTER  = 4'd10; // after removal: repost or continue

  logic [3:0]    state_q, state_d;
  logic [3:0]    ret_q, ret_d;       // state after read latency
  teq_in_t       item_q, item_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   clock_q, clock_d;
  logic [31:0]   adj_q, adj_d;
  logic [CW-1:0] idx_q, idx_d;       // scan index
  logic [CW-1:0] ptr_q, ptr_d;       // shift pointer
  logic [CW-1:0] pos_q, pos_d;
  logic [5:0]    ndisp_q, ndisp_d;
  logic          hit_q, hit_d;
  teq_entry_t    new_q, new_d;       // entry being inserted
  logic          repost_q, repost_d; // insert is a repost inside advance
  logic          cur_ok_q, cur_ok_d; // read data valid for the current read address
  teq_entry_t    cur_q, cur_d;
  teq_out_t      pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  teq_out_t      out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  teq_entry_t    wdata, rdata;

  teq_store #(.Depth(QUEUE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic [31:0] limit, rep_stamp;
  logic        out_free;
  assign limit    = clock_q + adj_q;
  assign out_free = !out_valid_q || !out_stall_i;

  function automatic teq_out_t done_word(logic [1:0] rk, logic [31:0] clk);
    teq_out_t w;
    w = '0;
    w.result_kind = rk;
    w.clock_now   = clk;
    w.last        = 1'b1;
    return w;
  endfunction

  // sequencer
  always_comb begin
    state_d = state_q; ret_d = ret_q; item_d = item_q; count_d = count_q;
    clock_d = clock_q; adj_d = adj_q; idx_d = idx_q; ptr_d = ptr_q;
    pos_d = pos_q; ndisp_d = ndisp_q; hit_d = hit_q; new_d = new_q;
    repost_d = repost_q; cur_ok_d = cur_ok_q; cur_d = cur_q; pend_d = pend_q;
    out_valid_d = out_valid_q && out_stall_i; out_d = out_q;
    we = 1'b0; waddr = '0; wdata = new_q; raddr = '0; rep_stamp = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          item_d = in_data_i; hit_d = 1'b0; idx_d = '0; repost_d = 1'b0;
          ndisp_d = '0; adj_d = in_data_i.adjustment; cur_ok_d = 1'b0;
          new_d.stamp  = in_data_i.due_stamp;
          new_d.param  = in_data_i.event_param;
          new_d.offset = in_data_i.time_offset;
          new_d.kind   = in_data_i.event_kind;
          new_d.cls    = in_data_i.event_class;
          case (in_data_i.opcode)
            OP_INSERT: begin
              if (count_q >= CW'(QUEUE_DEPTH)) begin
                pend_d = done_word(RK_FULL, clock_q); state_d = S_FIN;
              end else begin
                state_d = S_FIND;
              end
            end
            OP_DEL_PARAM, OP_DEL_KIND: state_d = S_SRCH;
            OP_CLEAR: begin
              count_d = '0; pend_d = done_word(RK_DONE, clock_q); state_d = S_FIN;
            end
            OP_ADVANCE: state_d = S_ADV;
            default: begin
              pend_d = done_word(RK_DONE, clock_q); state_d = S_FIN;
            end
          endcase
        end
      end

      S_WAIT: begin
        raddr = idx_q[AW-1:0];
        state_d = ret_q;
        cur_ok_d = 1'b1;
      end

      // find first entry with stamp above the new one
      S_FIND: begin
        raddr = idx_q[AW-1:0];
        if (idx_q >= count_q) begin
          pos_d = idx_q; ptr_d = count_q; cur_ok_d = 1'b0; state_d = S_SHUP;
        end else if (!cur_ok_q) begin
          ret_d = S_FIND; state_d = S_WAIT;
        end else if (rdata.stamp <= new_q.stamp) begin
          idx_d = idx_q + 1'b1; cur_ok_d = 1'b0;
        end else begin
          pos_d = idx_q; ptr_d = count_q; cur_ok_d = 1'b0; state_d = S_SHUP;
        end
      end

      // move entries ptr-1 to ptr until ptr reaches pos
      S_SHUP: begin
        raddr = AW'(ptr_q - 1'b1);
        if (ptr_q == pos_q) begin
          state_d = S_PUT;
        end else if (!cur_ok_q) begin
          cur_ok_d = 1'b1;
        end else begin
          we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = rdata;
          ptr_d = ptr_q - 1'b1; cur_ok_d = 1'b0;
        end
      end

      S_PUT: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wdata = new_q;
        count_d = count_q + 1'b1;
        if (repost_q) begin
          // a warp advance ends after its single dispatch
          idx_d = item_q.warp_target_first ? CW'(QUEUE_DEPTH) : '0;
          cur_ok_d = 1'b0; state_d = S_ADV;
        end else begin
          pend_d = done_word(RK_DONE, clock_q); state_d = S_FIN;
        end
      end

      // deletion search from idx
      S_SRCH: begin
        raddr = idx_q[AW-1:0];
        if (idx_q >= count_q) begin
          pend_d = done_word(hit_q ? RK_DONE : RK_NOTFOUND, clock_q);
          state_d = S_FIN;
        end else if (!cur_ok_q) begin
          ret_d = S_SRCH; state_d = S_WAIT;
        end else if (rdata.kind == item_q.event_kind &&
                     (item_q.opcode == OP_DEL_KIND || rdata.param == item_q.event_param)) begin
          hit_d = 1'b1; ptr_d = idx_q; cur_ok_d = 1'b0; ret_d = S_SRCH;
          state_d = S_SHDN;
        end else begin
          idx_d = idx_q + 1'b1; cur_ok_d = 1'b0;
        end
      end

      // move entries ptr+1 to ptr up to the tail, then drop one
      S_SHDN: begin
        raddr = AW'(ptr_q + 1'b1);
        if (ptr_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1; cur_ok_d = 1'b0;
          if (ret_q == S_SRCH && item_q.opcode == OP_DEL_PARAM) begin
            pend_d = done_word(RK_DONE, clock_q); state_d = S_FIN;
          end else begin
            state_d = ret_q;
          end
        end else if (!cur_ok_q) begin
          cur_ok_d = 1'b1;
        end else begin
          we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = rdata;
          ptr_d = ptr_q + 1'b1; cur_ok_d = 1'b0;
        end
      end

      // advance: examine entry idx
      S_ADV: begin
        raddr = idx_q[AW-1:0];
        if (idx_q >= count_q || ndisp_q == 6'(MaxDispatch)) begin
          clock_d = clock_q + adj_q;
          pend_d = done_word(RK_DONE, clock_q + adj_q); state_d = S_FIN;
        end else if (!cur_ok_q) begin
          ret_d = S_ADV; state_d = S_WAIT;
        end else if (rdata.stamp > limit) begin
          clock_d = clock_q + adj_q;
          pend_d = done_word(RK_DONE, clock_q + adj_q); state_d = S_FIN;
        end else if (item_q.warp_target_first && rdata.stamp != limit) begin
          idx_d = idx_q + 1'b1; cur_ok_d = 1'b0;
        end else if (item_q.warp_target_first && (idx_q + 1'b1 < count_q)
                     && !hit_q) begin
          // look at the successor before committing
          cur_d = rdata; hit_d = 1'b1; idx_d = idx_q + 1'b1; cur_ok_d = 1'b0;
        end else begin
          cur_d = rdata; hit_d = 1'b0;
          if (rdata.stamp > clock_q || item_q.warp_target_first) begin
            clock_d = rdata.stamp; adj_d = adj_q - (rdata.stamp - clock_q);
          end
          pend_d = '0;
          pend_d.result_kind = RK_DISPATCH;
          pend_d.out_kind = rdata.kind; pend_d.out_class = rdata.cls;
          pend_d.out_param = rdata.param; pend_d.out_stamp = rdata.stamp;
          pend_d.clock_now = (rdata.stamp > clock_q || item_q.warp_target_first)
                             ? rdata.stamp : clock_q;
          ndisp_d = ndisp_q + 1'b1;
          state_d = S_EMIT;
        end
        // warp successor check: hit_q holds the candidate in cur_q
        if (hit_q && cur_ok_q && idx_q < count_q && item_q.warp_target_first
            && ndisp_q != 6'(MaxDispatch)) begin
          if (rdata.stamp <= limit) begin
            hit_d = 1'b0; cur_ok_d = 1'b0; state_d = S_ADV;  // candidate skipped
            pend_d = pend_q; clock_d = clock_q; adj_d = adj_q; ndisp_d = ndisp_q;
            idx_d = idx_q;
          end else begin
            hit_d = 1'b0; idx_d = idx_q - 1'b1;
            clock_d = cur_q.stamp; adj_d = adj_q - (cur_q.stamp - clock_q);
            pend_d = '0;
            pend_d.result_kind = RK_DISPATCH;
            pend_d.out_kind = cur_q.kind; pend_d.out_class = cur_q.cls;
            pend_d.out_param = cur_q.param; pend_d.out_stamp = cur_q.stamp;
            pend_d.clock_now = cur_q.stamp;
            ndisp_d = ndisp_q + 1'b1;
            state_d = S_EMIT; cur_d = cur_q;
          end
        end
      end

      // hand a dispatch word to the output register, then remove the entry
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1; out_d = pend_q;
          ptr_d = idx_q; cur_ok_d = 1'b0; ret_d = S_AFTER; state_d = S_SHDN;
        end
      end

      S_AFTER: begin
        rep_stamp = (cur_q.cls == CLS_DAILY) ? cur_q.stamp + 32'(DAY_SECONDS)
                                             : cur_q.stamp + cur_q.offset;
        new_d.stamp = rep_stamp; new_d.param = cur_q.param; new_d.kind = cur_q.kind;
        new_d.cls = (cur_q.cls == CLS_RANGED) ? CLS_END : cur_q.cls;
        new_d.offset = (cur_q.cls == CLS_PERIODIC) ? cur_q.offset : 32'd0;
        cur_ok_d = 1'b0;
        if ((cur_q.cls == CLS_RANGED || cur_q.cls == CLS_PERIODIC ||
             cur_q.cls == CLS_DAILY) && rep_stamp > cur_q.stamp &&
            count_q < CW'(QUEUE_DEPTH)) begin
          repost_d = 1'b1; idx_d = '0; state_d = S_FIND;
        end else begin
          // a warp advance ends after its single dispatch
          idx_d = item_q.warp_target_first ? CW'(QUEUE_DEPTH) : '0;
          state_d = S_ADV;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1; out_d = pend_q; state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; clock_q <= '0; out_valid_q <= 1'b0;
      cur_ok_q <= 1'b0; hit_q <= 1'b0; repost_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; clock_q <= clock_d;
      out_valid_q <= out_valid_d; cur_ok_q <= cur_ok_d; hit_q <= hit_d;
      repost_q <= repost_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; item_q <= item_d; adj_q <= adj_d; idx_q <= idx_d;
    ptr_q <= ptr_d; pos_q <= pos_d; ndisp_q <= ndisp_d; new_q <= new_d;
    cur_q <= cur_d; pend_q <= pend_d; out_q <= out_d;
  end
endmodule

// ===== hw/rtl/teq_store.sv =====
// entry memory of the timed event queue: one write port, one registered read
// depends on teq_pkg
module teq_store #(
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  teq_pkg::teq_entry_t      wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output teq_pkg::teq_entry_t      rdata_o
);
  import teq_pkg::*;

  teq_entry_t mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/teq_checker.sv =====
// port-level checks of the timed event queue
// depends on teq_pkg; bound to timed_event_queue
module teq_port_checks (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input teq_pkg::teq_out_t out_data_o
);
  import teq_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  // dispatch words are never marked last
  a_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == RK_DISPATCH |-> !out_data_o.last)
    else $error("dispatch marked last");

  // non-dispatch words are final
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind != RK_DISPATCH |-> out_data_o.last)
    else $error("done word not last");

  // an accepted word makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");
endmodule

bind timed_event_queue teq_port_checks u_teq_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
